>>> design/expiry_timer_table_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef EXPIRY_TIMER_TABLE_UNIT_MACROS_SVH
`define EXPIRY_TIMER_TABLE_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ETT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property that must hold at every clock edge, reset included.
`define ETT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/ett_pkg.sv
`default_nettype none
package ett_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam int TIME_W = 49;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_NOP = 2'd3;

	localparam logic [2:0] KIND_ADDED = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_DELETED = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
	localparam logic [2:0] KIND_FIRED = 3'd4;
	localparam logic [2:0] KIND_NONE = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		logic [47:0] amount;
		logic [47:0] now_ms;
		logic in_seconds;
		logic periodic;
		logic [31:0] timer_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] result_id;
		logic last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic mul;        // form the delay product
		logic scan_clr;   // start a slot scan
		logic scan_step;  // examine one slot
		logic do_add;     // write the found free slot
		logic do_del;     // free the matched slot
		logic do_fire;    // fire the chosen slot
		logic clr_done;   // clear the per-tick fired marks
		logic emit;       // load the output register
		logic [2:0] kind;
		logic last;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_end;
		logic found;
		logic out_busy;
		logic [1:0] mode;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> design/ett_datapath.sv
`default_nettype none
module ett_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire ett_pkg::in_item_t in_item,
	input wire ett_pkg::ctl_cmd_t cmd,
	output ett_pkg::dp_stat_t stat,
	output ett_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_stall
);
	import ett_pkg::*;

	logic [TIMER_SLOTS-1:0] valid_q, done_q;
	logic [TIME_W-1:0] expiry_q [TIMER_SLOTS];
	logic [TIME_W-1:0] period_q [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] repeat_q;
	logic [31:0] ident_q [TIMER_SLOTS];
	logic [31:0] order_q [TIMER_SLOTS];
	logic [31:0] next_ident_q, order_cnt_q;

	in_item_t item_q;
	logic [57:0] prod_q;
	logic [TIME_W-1:0] delay;
	logic [SLOT_W:0] idx_q;
	logic [SLOT_W-1:0] idx;
	logic [SLOT_W-1:0] best_q;
	logic found_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [31:0] best_age_q;
	logic [31:0] age;
	logic cand;
	logic [TIME_W:0] sum_add, sum_fire;
	logic [TIME_W-1:0] exp_add, exp_fire;
	logic [31:0] out_id;

	assign idx = idx_q[SLOT_W-1:0];
	assign delay = (prod_q[57:TIME_W] != '0) ? TIME_MAX : prod_q[TIME_W-1:0];
	assign sum_add = {2'b00, item_q.now_ms} + {1'b0, delay};
	assign exp_add = sum_add[TIME_W] ? TIME_MAX : sum_add[TIME_W-1:0];
	assign sum_fire = {2'b00, item_q.amount} + {1'b0, period_q[best_q]};
	assign exp_fire = sum_fire[TIME_W] ? TIME_MAX : sum_fire[TIME_W-1:0];
	assign age = order_cnt_q - order_q[idx];

	// Candidate test for the slot under the scan pointer, per mode.
	always_comb begin
		cand = 1'b0;
		unique case (item_q.mode)
			MODE_ADD: cand = !valid_q[idx] && !found_q;
			MODE_DEL: cand = valid_q[idx] && !found_q && ident_q[idx] == item_q.timer_id;
			MODE_TICK: cand = valid_q[idx] && !done_q[idx]
				&& expiry_q[idx] <= {1'b0, item_q.amount}
				&& (!found_q || expiry_q[idx] < best_exp_q
					|| (expiry_q[idx] == best_exp_q && age > best_age_q));
			default: cand = 1'b0;
		endcase
	end

	assign stat.scan_end = idx_q == (SLOT_W + 1)'(TIMER_SLOTS - 1) && cmd.scan_step;
	assign stat.found = found_q;
	assign stat.out_busy = out_valid;
	assign stat.mode = item_q.mode;

	// Item capture, delay product and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_item;
		if (cmd.mul) prod_q <= item_q.in_seconds
			? {10'd0, item_q.amount} * {48'd0, MS_PER_SECOND}
			: {10'd0, item_q.amount};
		if (cmd.scan_step && cand) begin
			best_q <= idx;
			best_exp_q <= expiry_q[idx];
			best_age_q <= age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			idx_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cand) found_q <= 1'b1;
		end
	end

	// Slot table writes.
	always_ff @(posedge clk) begin
		if (cmd.do_add) begin
			expiry_q[best_q] <= exp_add;
			period_q[best_q] <= delay;
			repeat_q[best_q] <= item_q.periodic;
			ident_q[best_q] <= next_ident_q;
			order_q[best_q] <= order_cnt_q;
		end else if (cmd.do_fire && repeat_q[best_q]) begin
			expiry_q[best_q] <= exp_fire;
			order_q[best_q] <= order_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q <= '0;
			next_ident_q <= '0;
			order_cnt_q <= '0;
		end else begin
			if (cmd.clr_done) done_q <= '0;
			if (cmd.do_add) begin
				valid_q[best_q] <= 1'b1;
				next_ident_q <= next_ident_q + 1'b1;
				order_cnt_q <= order_cnt_q + 1'b1;
			end
			if (cmd.do_del) valid_q[best_q] <= 1'b0;
			if (cmd.do_fire) begin
				done_q[best_q] <= 1'b1;
				if (repeat_q[best_q]) order_cnt_q <= order_cnt_q + 1'b1;
				else valid_q[best_q] <= 1'b0;
			end
		end
	end

	// Output register; the id comes from the command kind.
	always_comb begin
		case (cmd.kind)
			KIND_ADDED: out_id = next_ident_q;
			KIND_DELETED, KIND_NOT_FOUND: out_id = item_q.timer_id;
			KIND_FIRED: out_id = ident_q[best_q];
			default: out_id = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item.kind <= cmd.kind;
			out_item.result_id <= out_id;
			out_item.last <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

endmodule
`default_nettype wire

>>> design/ett_ctrl.sv
`default_nettype none
module ett_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire ett_pkg::dp_stat_t stat,
	output ett_pkg::ctl_cmd_t cmd
);
	import ett_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_ACT = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;

	logic [2:0] state_q, state_d;
	logic [CNT_W-1:0] fired_q;
	logic can_emit;

	assign can_emit = !stat.out_busy;
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				cmd.scan_clr = 1'b1;
				cmd.clr_done = 1'b1;
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = (stat.mode == MODE_NOP) ? ST_IDLE : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_end) state_d = ST_ACT;
			end
			ST_ACT: begin
				if (can_emit) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d = ST_IDLE;
					unique case (stat.mode)
						MODE_ADD: begin
							cmd.kind = stat.found ? KIND_ADDED : KIND_FULL;
							cmd.do_add = stat.found;
						end
						MODE_DEL: begin
							cmd.kind = stat.found ? KIND_DELETED : KIND_NOT_FOUND;
							cmd.do_del = stat.found;
						end
						default: begin
							if (stat.found && fired_q != CNT_W'(MAX_RESULTS)) begin
								cmd.kind = KIND_FIRED;
								cmd.do_fire = 1'b1;
								cmd.last = 1'b0;
								cmd.scan_clr = 1'b1;
								state_d = ST_WAIT;
							end else if (fired_q == '0) begin
								cmd.kind = KIND_NONE;
							end else begin
								// Closing marker: the look-ahead stage marks its held
								// fired result as the final one.
								cmd.kind = KIND_FIRED;
							end
						end
					endcase
				end
			end
			ST_WAIT: state_d = ST_SCAN;
			default: state_d = ST_IDLE;
		endcase
	end

	// State register and the count of timers fired by the current tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fired_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) fired_q <= '0;
			else if (cmd.do_fire) fired_q <= fired_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> design/ett_lookahead.sv
`default_nettype none
module ett_lookahead (
	input wire logic clk,
	input wire logic arst_n,
	input wire ett_pkg::out_item_t raw_item,
	input wire logic raw_valid,
	input wire logic raw_final,
	output logic raw_stall,
	output ett_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_stall
);
	import ett_pkg::*;

	// Holds one fired result until the next result or the tick end shows
	// whether it is the final one.
	out_item_t hold_q;
	logic hold_q_v;

	assign raw_stall = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q_v <= 1'b0;
			out_valid <= 1'b0;
		end else if (!raw_stall) begin
			out_valid <= 1'b0;
			if (raw_final) begin
				if (hold_q_v) begin
					out_valid <= 1'b1;
					hold_q_v <= 1'b0;
				end
			end else if (raw_valid) begin
				if (raw_item.kind == KIND_FIRED && !raw_item.last) begin
					if (hold_q_v) out_valid <= 1'b1;
					hold_q_v <= 1'b1;
				end else begin
					out_valid <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!raw_stall) begin
			if (raw_final) begin
				out_item <= '{kind: hold_q.kind, result_id: hold_q.result_id, last: 1'b1};
			end else if (raw_valid) begin
				if (raw_item.kind == KIND_FIRED && !raw_item.last) begin
					out_item <= hold_q;
					hold_q <= raw_item;
				end else begin
					out_item <= raw_item;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> design/expiry_timer_table_unit.sv
`default_nettype none
// Table of TIMER_SLOTS one-shot or periodic timers with items add, delete and
// tick. Every add, delete or tick item is handled by linear scans of the slot
// table, one slot a cycle through a single compare unit; an unused mode code is
// dropped without a scan. An add or delete holds the input until its scan is
// done and its result is emitted; a tick holds it through one rescan per fired
// timer, and a stalled output holds it longer.
// A tick's fired results leave in expiry order, ties oldest first, and the
// final result of each item carries last; the newest fired result waits in a
// look-ahead stage until the next one or the end of the tick.
module expiry_timer_table_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire ett_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output ett_pkg::out_item_t out_item
);
	import ett_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;
	out_item_t raw_item;
	logic raw_valid, raw_stall, raw_final;
	ctl_cmd_t cmd_g;

	// The datapath output register is taken by the look-ahead stage.
	ett_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall,
		.stat, .cmd
	);

	// A fired result flagged last is the tick's closing marker.
	assign raw_final = raw_valid && raw_item.kind == KIND_FIRED && raw_item.last;
	assign cmd_g = cmd;

	ett_datapath u_dp (
		.clk, .arst_n, .in_item, .cmd(cmd_g), .stat,
		.out_item(raw_item), .out_valid(raw_valid), .out_stall(raw_stall)
	);

	ett_lookahead u_la (
		.clk, .arst_n, .raw_item, .raw_valid, .raw_final, .raw_stall,
		.out_item, .out_valid, .out_stall
	);

endmodule
`default_nettype wire

>>> design/ett_checker.sv
`default_nettype none
`include "expiry_timer_table_unit_macros.svh"
module ett_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire ett_pkg::in_item_t in_item,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire ett_pkg::out_item_t out_item
);
	import ett_pkg::*;

	`ETT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "output changed under stall")
	`ETT_ASSERT(a_kind_range, out_valid |-> out_item.kind <= KIND_NONE, "result kind out of range")
	`ETT_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall, "second item taken while busy")
	`ETT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "output valid in reset")

endmodule
bind expiry_timer_table_unit ett_checker u_chk (.*);
`default_nettype wire

>>> dv/expiry_timer_table_unit_test.sv
`default_nettype none
module expiry_timer_table_unit_test;
	import ett_pkg::*;

	localparam logic [48:0] T_MAX = {49{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	in_item_t in_item = '0;
	logic in_stall;
	logic out_valid;
	out_item_t out_item;

	expiry_timer_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always #4 clk = ~clk;

	// Shadow copy of the timer table.
	logic        tv_valid [TIMER_SLOTS];
	logic [48:0] tv_expiry [TIMER_SLOTS];
	logic [48:0] tv_period [TIMER_SLOTS];
	logic        tv_repeat [TIMER_SLOTS];
	logic [31:0] tv_ident [TIMER_SLOTS];
	logic [31:0] tv_order [TIMER_SLOTS];
	logic [31:0] id_next;
	logic [31:0] order_next;

	out_item_t pending_results[$];
	int error_count = 0;
	int live_ids[$];
	bit quiet = 1'b0;
	bit hold_rx = 1'b0;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic logic [48:0] sat_sum(input logic [48:0] a, input logic [48:0] b);
		logic [49:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[49] ? T_MAX : s[48:0];
	endfunction

	function automatic out_item_t make_result(input logic [2:0] k, input logic [31:0] id,
		input logic l);
		out_item_t r;
		r.kind = k;
		r.result_id = id;
		r.last = l;
		return r;
	endfunction

	// Append one expected result to the scoreboard.
	task automatic expect_result(input out_item_t r);
		pending_results.insert(pending_results.size(), r);
	endtask

	// Work out the results of one accepted item and update the shadow table.
	task automatic predict_timers(input in_item_t it);
		logic [63:0] delay;
		bit done [TIMER_SLOTS];
		int n;
		int best;
		logic [31:0] best_age;
		logic [31:0] age;
		bit hit;
		n = 0;
		hit = 0;
		case (it.mode)
			MODE_ADD: begin
				delay = it.in_seconds ? {16'd0, it.amount} * 64'd1000 : {16'd0, it.amount};
				if (delay > {15'd0, T_MAX}) delay = {15'd0, T_MAX};
				for (int i = 0; i < TIMER_SLOTS && !hit; i++) begin
					if (!tv_valid[i]) begin
						hit = 1;
						tv_valid[i] = 1;
						tv_expiry[i] = sat_sum({1'b0, it.now_ms}, delay[48:0]);
						tv_period[i] = delay[48:0];
						tv_repeat[i] = it.periodic;
						tv_ident[i] = id_next;
						tv_order[i] = order_next;
						order_next++;
						live_ids.insert(live_ids.size(), int'(id_next));
						expect_result(make_result(KIND_ADDED, id_next, 1'b1));
						id_next++;
					end
				end
				if (!hit) expect_result(make_result(KIND_FULL, 32'd0, 1'b1));
			end
			MODE_DEL: begin
				for (int i = 0; i < TIMER_SLOTS && !hit; i++) begin
					if (tv_valid[i] && tv_ident[i] == it.timer_id) begin
						hit = 1;
						tv_valid[i] = 0;
					end
				end
				expect_result(make_result(hit ? KIND_DELETED : KIND_NOT_FOUND,
					it.timer_id, 1'b1));
			end
			MODE_TICK: begin
				foreach (done[i]) done[i] = 0;
				while (n < MAX_RESULTS) begin
					best = -1;
					best_age = 0;
					for (int i = 0; i < TIMER_SLOTS; i++) begin
						if (tv_valid[i] && !done[i] && tv_expiry[i] <= {1'b0, it.amount}) begin
							age = order_next - tv_order[i];
							if (best < 0 || tv_expiry[i] < tv_expiry[best] ||
								(tv_expiry[i] == tv_expiry[best] && age > best_age)) begin
								best = i;
								best_age = age;
							end
						end
					end
					if (best < 0) break;
					done[best] = 1;
					expect_result(make_result(KIND_FIRED, tv_ident[best], 1'b0));
					n++;
					if (tv_repeat[best]) begin
						tv_expiry[best] = sat_sum({1'b0, it.amount}, tv_period[best]);
						tv_order[best] = order_next;
						order_next++;
					end else begin
						tv_valid[best] = 0;
					end
				end
				if (n == 0) expect_result(make_result(KIND_NONE, 32'd0, 1'b1));
				else pending_results[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d id=%0d",
					out_item.kind, out_item.result_id));
			end else begin
				exp_r = pending_results.pop_front();
				if (out_item.kind !== exp_r.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", out_item.kind, exp_r.kind));
				if (out_item.result_id !== exp_r.result_id)
					report_mismatch($sformatf("id %0d, expected %0d",
						out_item.result_id, exp_r.result_id));
				if (out_item.last !== exp_r.last)
					report_mismatch($sformatf("last %0d, expected %0d", out_item.last, exp_r.last));
			end
		end
	end

	// Receiver stalls in short random bursts, or for a long hold-off when asked.
	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				for (int c = 0; c < 600; c++) @(negedge clk);
				hold_rx = 0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 3);
				out_stall <= 1'b1;
				for (int c = 1; c < burst; c++) @(negedge clk);
				@(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item and hold it until its transfer.
	task automatic send_item(input in_item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_timers(it);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic in_item_t build(input logic [1:0] m, input logic [47:0] a,
		input logic [47:0] n, input logic s, input logic p, input logic [31:0] id);
		in_item_t it;
		it.mode = m;
		it.amount = a;
		it.now_ms = n;
		it.in_seconds = s;
		it.periodic = p;
		it.timer_id = id;
		return it;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	// Directed stimulus with literal expectations where they are obvious.
	typedef struct {
		in_item_t it;
		bit       has_exp;
		logic [2:0] kind;
		logic [31:0] id;
	} dir_row_t;

	dir_row_t dir_rows[$];
	logic [47:0] clock_ms;

	task automatic add_row(input in_item_t it, input bit h, input logic [2:0] k,
		input logic [31:0] id);
		dir_row_t r;
		r.it = it;
		r.has_exp = h;
		r.kind = k;
		r.id = id;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	initial begin
		in_item_t it;
		int r;
		// Directed table: reset state, extremes, full table, wrap of a tick.
		add_row(build(MODE_TICK, '0, '0, 1'b0, 1'b0, '0), 1'b1, KIND_NONE, 32'd0);
		add_row(build(MODE_DEL, '0, '0, 1'b0, 1'b0, '1), 1'b1, KIND_NOT_FOUND,
			32'hFFFF_FFFF);
		add_row(build(MODE_ADD, '1, '1, 1'b1, 1'b1, '0), 1'b1, KIND_ADDED, 32'd0);
		add_row(build(MODE_ADD, '1, '0, 1'b1, 1'b0, '0), 1'b1, KIND_ADDED, 32'd1);
		add_row(build(MODE_ADD, '0, '0, 1'b0, 1'b1, '0), 1'b1, KIND_ADDED, 32'd2);
		add_row(build(MODE_ADD, 48'd5, 48'd10, 1'b0, 1'b0, '0), 1'b1, KIND_ADDED, 32'd3);
		add_row(build(MODE_NOP, '1, '1, 1'b1, 1'b1, '1), 1'b0, KIND_ADDED, 32'd0);
		add_row(build(MODE_TICK, 48'd15, '0, 1'b0, 1'b0, '0), 1'b0, KIND_ADDED, 32'd0);
		add_row(build(MODE_TICK, '1, '1, 1'b1, 1'b1, '1), 1'b0, KIND_ADDED, 32'd0);
		for (int i = 0; i < 17; i++)
			add_row(build(MODE_ADD, 48'd3, 48'd7, i[0], i[1], '0), 1'b0, KIND_ADDED, 32'd0);
		add_row(build(MODE_DEL, '0, '0, 1'b0, 1'b0, 32'd2), 1'b1, KIND_DELETED, 32'd2);
		add_row(build(MODE_TICK, '1, '0, 1'b0, 1'b0, '0), 1'b0, KIND_ADDED, 32'd0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		id_next = 0;
		order_next = 0;
		foreach (tv_valid[i]) tv_valid[i] = 0;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			send_item(dir_rows[k].it);
			if (dir_rows[k].has_exp && !(pending_results.size() != 0 &&
				pending_results[$].kind == dir_rows[k].kind &&
				pending_results[$].result_id == dir_rows[k].id))
				report_mismatch($sformatf("directed row %0d predicts differently", k));
		end
		// Sender pause until the table has answered everything.
		drain_results();
		// Long receiver hold-off while items keep coming.
		hold_rx = 1;
		clock_ms = 48'd1000;
		for (int n = 0; n < 155; n++) begin
			if (n == 130) quiet = 1;
			r = $urandom_range(0, 99);
			clock_ms += 48'($urandom_range(0, 40));
			if (r < 45)
				it = build(MODE_ADD,
					$urandom_range(0, 3) == 0 ? rand48() : 48'($urandom_range(0, 60)),
					clock_ms, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
					$urandom());
			else if (r < 65)
				it = build(MODE_DEL, rand48(), rand48(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)),
					(live_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
					32'(live_ids[$urandom_range(0, live_ids.size() - 1)]) : $urandom());
			else if (r < 97)
				it = build(MODE_TICK, clock_ms, rand48(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom());
			else
				it = build(MODE_NOP, rand48(), rand48(), 1'b1, 1'b1, $urandom());
			send_item(it);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
